FILE: rtl/itp_pkg.sv
package itp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CHAR_W      = 8;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int PREC_W      = 3;

   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
   localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

   // stack control word from the sequencer
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [CHAR_W-1:0] data;
   } stk_ctl_type;

   function automatic logic [PREC_W-1:0] prec_in(input logic [CHAR_W-1:0] c);
      logic [PREC_W-1:0] p;
      p = PREC_W'(0);
      if (c == CH_PLUS || c == CH_MINUS) p = PREC_W'(1);
      else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) p = PREC_W'(2);
      else if (c == CH_CARET) p = PREC_W'(4);
      else if (c == CH_LPAR) p = PREC_W'(5);
      return p;
   endfunction

   function automatic logic [PREC_W-1:0] prec_stk(input logic [CHAR_W-1:0] c);
      logic [PREC_W-1:0] p;
      p = PREC_W'(0);
      if (c == CH_PLUS || c == CH_MINUS) p = PREC_W'(1);
      else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) p = PREC_W'(2);
      else if (c == CH_CARET) p = PREC_W'(3);
      return p;
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
   endfunction

endpackage

FILE: rtl/itp_req_if.sv
interface itp_req_if import itp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   logic              end_of_expr;

   modport source (output valid, output in_char, output end_of_expr, input ready);
   modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

FILE: rtl/itp_rsp_if.sv
interface itp_rsp_if import itp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              expr_done;
   logic              run_last;
   logic              error_flag;

   modport source (output valid, output out_char, output expr_done, output run_last,
                   output error_flag, input ready);
   modport sink   (input valid, input out_char, input expr_done, input run_last,
                   input error_flag, output ready);
endinterface

FILE: rtl/infix_to_postfix_converter_top.sv
// Infix to postfix converter (shunting-yard). Each input word carries one
// ASCII character or an end marker; each output word carries one postfix
// character, the final marker (expr_done) or an error (error_flag), with
// run_last set on the last word an input word causes. Letters pass straight
// through, operators are held on a 16-entry stack and popped by precedence.
// A word that pops nothing (letter, push, lone error) is handled in the
// decide state alone, as is a ')' that meets its '(' at once; a word that
// pops entries (operator, ')' or end flush) goes on into the pop loop, one
// stack entry per cycle through the single precedence comparator while the
// output register can take each result. The block takes no new word until
// the current one is finished; a result waiting in the output register stalls
// the sequencer only when a further result is due. Reset empties the stack.
module infix_to_postfix_converter_top import itp_pkg::*; (
   input logic       clock,
   input logic       reset,
   itp_req_if.sink   req_chan,
   itp_rsp_if.source rsp_chan
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECIDE = 4'd1;  // first look at top of stack
   localparam logic [3:0] ST_FLUSH  = 4'd2;  // end word: pop everything
   localparam logic [3:0] ST_MARK   = 4'd3;  // end word: final marker
   localparam logic [3:0] ST_CLOSE  = 4'd4;  // ')': pop to matching '('
   localparam logic [3:0] ST_DROP   = 4'd5;  // ')': discard the '('
   localparam logic [3:0] ST_OPPOP  = 4'd6;  // operator: pop by precedence
   localparam logic [3:0] ST_PUSH   = 4'd7;  // operator: push after pops
   localparam logic [3:0] ST_ERR    = 4'd8;  // unmatched ')': error word

   logic [3:0]        state_ff, state_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              end_ff, end_in;

   stk_ctl_type       ctl;
   logic [CNT_W-1:0]  count;
   logic [CHAR_W-1:0] top, below;
   logic [CHAR_W-1:0] cmp_char;
   logic              pops;
   logic              full;

   logic              accept;
   logic              out_free;
   logic              emit;
   logic [CHAR_W-1:0] e_char;
   logic              e_done, e_last, e_err;

   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_done_ff, rsp_last_ff, rsp_err_ff;

   itp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .count (count),
      .top   (top),
      .below (below)
   );

   // in the pop loop the comparator looks one entry ahead to set run_last
   assign cmp_char = (state_ff == ST_OPPOP) ? below : top;

   itp_prec u_prec (
      .in_char  (ch_ff),
      .stk_char (cmp_char),
      .pops     (pops)
   );

   assign full     = count == CNT_W'(STACK_DEPTH);
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      end_in   = end_ff;
      ctl.push = 1'b0;
      ctl.pop  = 1'b0;
      ctl.data = ch_ff;
      emit     = 1'b0;
      e_char   = '0;
      e_done   = 1'b0;
      e_last   = 1'b0;
      e_err    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in    = req_chan.in_char;
               end_in   = req_chan.end_of_expr;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (end_ff) begin
               if (count != '0) begin
                  state_in = ST_FLUSH;
               end else if (out_free) begin
                  emit     = 1'b1;
                  e_done   = 1'b1;
                  e_last   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (is_letter(ch_ff)) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_char   = ch_ff;
                  e_last   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (ch_ff == CH_RPAR) begin
               if (count == '0) begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_err    = 1'b1;
                     e_last   = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else if (top == CH_LPAR) begin
                  ctl.pop  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CLOSE;
               end
            end else if (ch_ff != CH_LPAR && count != '0 && pops) begin
               state_in = ST_OPPOP;
            end else if (full) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_err    = 1'b1;
                  e_last   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               ctl.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               emit    = 1'b1;
               e_char  = top;
               ctl.pop = 1'b1;
               if (count == CNT_W'(1)) state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               emit     = 1'b1;
               e_done   = 1'b1;
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               emit    = 1'b1;
               e_char  = top;
               ctl.pop = 1'b1;
               if (count == CNT_W'(1)) begin
                  state_in = ST_ERR;
               end else if (below == CH_LPAR) begin
                  e_last   = 1'b1;
                  state_in = ST_DROP;
               end
            end
         end
         ST_DROP: begin
            ctl.pop  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_OPPOP: begin
            if (out_free) begin
               emit    = 1'b1;
               e_char  = top;
               ctl.pop = 1'b1;
               if (count == CNT_W'(1) || !pops) begin
                  e_last   = 1'b1;
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            ctl.push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_ERR: begin
            if (out_free) begin
               emit     = 1'b1;
               e_err    = 1'b1;
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff  <= ch_in;
      end_ff <= end_in;
      if (emit) begin
         rsp_char_ff <= e_char;
         rsp_done_ff <= e_done;
         rsp_last_ff <= e_last;
         rsp_err_ff  <= e_err;
      end
   end

   assign req_chan.ready      = state_ff == ST_IDLE;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_char   = rsp_char_ff;
   assign rsp_chan.expr_done  = rsp_done_ff;
   assign rsp_chan.run_last   = rsp_last_ff;
   assign rsp_chan.error_flag = rsp_err_ff;

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DECIDE)
      else $error("accepted word not decoded");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_done_ff || rsp_err_ff)) |-> (rsp_last_ff && rsp_char_ff == '0))
      else $error("marker or error word malformed");
   a_idle_stack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |=> $stable(count))
      else $error("stack moved while idle");
endmodule

FILE: rtl/itp_prec.sv
// shared precedence compare: stacked entry pops if its precedence >= incoming
module itp_prec import itp_pkg::*; (
   input  logic [CHAR_W-1:0] in_char,
   input  logic [CHAR_W-1:0] stk_char,
   output logic              pops
);
   assign pops = prec_stk(stk_char) >= prec_in(in_char);
endmodule

FILE: rtl/itp_stack.sv
// operator stack: memory plus registered copies of the two top entries
module itp_stack import itp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  stk_ctl_type       ctl,
   output logic [CNT_W-1:0]  count,
   output logic [CHAR_W-1:0] top,
   output logic [CHAR_W-1:0] below
);
   logic [CHAR_W-1:0] mem [STACK_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  top_addr, below_addr;
   logic [CHAR_W-1:0] top_ff, below_ff;

   assign count_in   = count_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
   assign top_addr   = count_in - CNT_W'(1);
   assign below_addr = count_in - CNT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // read addresses follow the next count; push bypasses the memory
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[count_ff[IDX_W-1:0]] <= ctl.data;
         top_ff                   <= ctl.data;
         below_ff                 <= top_ff;
      end else begin
         top_ff   <= mem[top_addr[IDX_W-1:0]];
         below_ff <= mem[below_addr[IDX_W-1:0]];
      end
   end

   assign count = count_ff;
   assign top   = top_ff;
   assign below = below_ff;

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> count_ff != '0)
      else $error("pop on empty stack");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> count_ff < CNT_W'(STACK_DEPTH))
      else $error("push on full stack");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop))
      else $error("push and pop together");
endmodule
